@@ hw/rtl/windowed_triple_subsequence_count_macros.svh @@
// Assertion macros used by the windowed triple counter checker.
`ifndef WINDOWED_TRIPLE_SUBSEQUENCE_COUNT_MACROS_SVH
`define WINDOWED_TRIPLE_SUBSEQUENCE_COUNT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WTSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wtsc check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define WTSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtsc check failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define WTSC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wtsc check failed: reset behavior");

`endif

@@ hw/rtl/wtsc_pkg.sv @@
// Package: types, widths and register codes of the windowed triple counter.
package wtsc_pkg;

  // Delay line depth and derived widths
  localparam int MAX_WINDOW = 4096;
  localparam int HIST_AW    = $clog2(MAX_WINDOW);
  localparam int CNT_W      = 13;
  localparam int PAIR_W     = 24;
  localparam int TOTAL_W    = 63;
  localparam int WLEN_W     = 13;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_CHAR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_CHAR  = 2'd3;

  // Register reset values
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 13'd3;
  localparam logic [7:0]        FIRST_RST      = 8'd68;  // D
  localparam logic [7:0]        SECOND_RST     = 8'd77;  // M
  localparam logic [7:0]        THIRD_RST      = 8'd67;  // C

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] triple_count;
    logic               final_count;
  } out_word_t;

endpackage

@@ hw/rtl/wtsc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module wtsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/windowed_triple_subsequence_count.sv @@
// Windowed triple counter: one character word per cycle, one result word per input
// word, registered in stage 1 and then in the output register. Stage 0 writes the
// character into a 4096-entry delay-line RAM and reads the character that leaves the
// window; stage 1 updates the first, second and pair counts and the running total
// from the registered read. The combinational window-count update in stage 1 sets the
// rate of one word per cycle; a stalled output register holds stage 1 and then input.
// The delay line needs no clearing after reset. A word with end_of_string set returns
// the string total with final_count high and clears all counts; registers keep values.
module windowed_triple_subsequence_count
  import wtsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [WLEN_W-1:0]     cfg_wdata
);

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [PAIR_W-1:0]  PAIR_MAX  = {PAIR_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [WLEN_W-1:0]  WMAX      = WLEN_W'(MAX_WINDOW);
  localparam logic [HIST_AW-1:0] BACK_MAX  = HIST_AW'(MAX_WINDOW - 1);

  // Configuration registers
  logic [WLEN_W-1:0] window_len_r;
  logic [7:0]        first_char_r, second_char_r, third_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= WINDOW_LEN_RST;
      first_char_r  <= FIRST_RST;
      second_char_r <= SECOND_RST;
      third_char_r  <= THIRD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW_LEN:  window_len_r  <= cfg_wdata;
        REG_FIRST_CHAR:  first_char_r  <= cfg_wdata[7:0];
        REG_SECOND_CHAR: second_char_r <= cfg_wdata[7:0];
        REG_THIRD_CHAR:  third_char_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Distance back to the leaving character: window clamped to 1..MAX_WINDOW, minus one
  logic [HIST_AW-1:0] back;
  always_comb begin
    if (window_len_r == '0) begin
      back = '0;
    end else if (window_len_r > WMAX) begin
      back = BACK_MAX;
    end else begin
      back = HIST_AW'(window_len_r - WLEN_W'(1));
    end
  end

  // Handshake
  logic s1_v_r, out_v_r;
  logic advance, accept, s1_fire;

  assign advance  = !out_v_r || !out_stall;
  assign in_stall = s1_v_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign s1_fire  = s1_v_r && advance;

  // Stage 0: delay-line position and per-string fill count
  logic [HIST_AW-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic               leave, back0;
  logic [HIST_AW-1:0] rd_addr;

  assign leave   = {1'b0, back} <= seen_r;
  assign back0   = back == '0;
  assign rd_addr = pos_r - back;

  always_comb begin
    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    if (accept) begin
      if (in_data.end_of_string) begin
        pos_nxt  = '0;
        seen_nxt = '0;
      end else begin
        pos_nxt  = pos_r + HIST_AW'(1);
        seen_nxt = (seen_r < WMAX) ? seen_r + CNT_W'(1) : seen_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      seen_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
    end
  end

  // Delay line; window of one uses the current character, so no same-entry read
  logic [7:0] hist_rdata;

  wtsc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (pos_r),
    .wdata (in_data.char_in),
    .re    (accept && leave && !back0),
    .raddr (rd_addr),
    .rdata (hist_rdata)
  );

  // Stage 1 pipeline registers
  logic [7:0] s1_c_r;
  logic       s1_leave_r, s1_back0_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c_r     <= in_data.char_in;
      s1_leave_r <= leave;
      s1_back0_r <= back0;
      s1_last_r  <= in_data.end_of_string;
    end
  end

  // Stage 1: window counts and total
  logic [CNT_W-1:0]   first_r, second_r, first_nxt, second_nxt, f_add, s_add;
  logic [PAIR_W-1:0]  pairs_r, pairs_nxt, p_add;
  logic [PAIR_W:0]    p_sum;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W:0]   t_sum;
  logic [7:0]         old_c;
  logic               in_first, in_second, in_third, old_first, old_second;

  assign old_c      = s1_back0_r ? s1_c_r : hist_rdata;
  assign in_first   = s1_c_r == first_char_r;
  assign in_second  = !in_first && (s1_c_r == second_char_r);
  assign in_third   = !in_first && !in_second && (s1_c_r == third_char_r);
  assign old_first  = s1_leave_r && (old_c == first_char_r);
  assign old_second = s1_leave_r && !old_first && (old_c == second_char_r);

  always_comb begin
    // entering character
    f_add = (in_first && first_r != CNT_MAX) ? first_r + CNT_W'(1) : first_r;
    s_add = (in_second && second_r != CNT_MAX) ? second_r + CNT_W'(1) : second_r;
    p_sum = {1'b0, pairs_r} + (in_second ? (PAIR_W+1)'(first_r) : '0);
    p_add = p_sum[PAIR_W] ? PAIR_MAX : p_sum[PAIR_W-1:0];
    t_sum = {1'b0, total_r} + (TOTAL_W+1)'(pairs_r);
    total_nxt = total_r;
    if (in_third) begin
      total_nxt = t_sum[TOTAL_W] ? TOTAL_MAX : t_sum[TOTAL_W-1:0];
    end
    // leaving character
    first_nxt  = f_add;
    second_nxt = s_add;
    pairs_nxt  = p_add;
    if (old_first) begin
      first_nxt = (f_add != '0) ? f_add - CNT_W'(1) : '0;
      pairs_nxt = (p_add > PAIR_W'(s_add)) ? p_add - PAIR_W'(s_add) : '0;
    end else if (old_second) begin
      second_nxt = (s_add != '0) ? s_add - CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      pairs_r  <= '0;
      total_r  <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        first_r  <= '0;
        second_r <= '0;
        pairs_r  <= '0;
        total_r  <= '0;
      end else begin
        first_r  <= first_nxt;
        second_r <= second_nxt;
        pairs_r  <= pairs_nxt;
        total_r  <= total_nxt;
      end
    end
  end

  // Output register
  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (advance) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.triple_count <= total_nxt;
      out_data_r.final_count  <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/wtsc_checker.sv @@
// Port-level checker for the windowed triple counter, bound to the top level.
`include "windowed_triple_subsequence_count_macros.svh"

module wtsc_checker
  import wtsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data
);

  // stalled result word holds
  `WTSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // input is never held off while the output side is empty
  `WTSC_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)

  // every accepted word is followed by a valid result word, its own or an older stalled one
  `WTSC_ASSERT_NOW(a_latency, in_valid && !in_stall, ##2 out_valid)

  // reset empties the output register
  `WTSC_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind windowed_triple_subsequence_count wtsc_checker u_wtsc_checker (.*);

@@ bench/windowed_triple_subsequence_count_test.sv @@
// Self-checking testbench for the windowed triple subsequence counter.
`timescale 1ns / 100ps

module windowed_triple_subsequence_count_test;
  import wtsc_pkg::*;

  localparam int GAP_MAX        = 14;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int REPORT_MAX     = 10;
  localparam int TAIL_CYCLES    = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;
  localparam logic [PAIR_W-1:0]  PAIR_SAT  = '1;
  localparam logic [CNT_W-1:0]   CNT_SAT   = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WLEN_W-1:0]    cfg_wdata;

  windowed_triple_subsequence_count u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted register file
  logic [WLEN_W-1:0] win_len_reg;
  logic [7:0]        pat_first;
  logic [7:0]        pat_second;
  logic [7:0]        pat_third;

  // Predicted string state
  logic [7:0]         char_delay [MAX_WINDOW];
  logic [HIST_AW-1:0] wr_slot;
  logic [12:0]        chars_seen;
  logic [CNT_W-1:0]   firsts_open;
  logic [CNT_W-1:0]   seconds_open;
  logic [PAIR_W-1:0]  pairs_open;
  logic [TOTAL_W-1:0] running_total;

  out_word_t expected_counts [$];

  int  words_sent;
  int  words_checked;
  int  failures;
  int  phases;
  int  reg_writes;
  int  mid_string_changes;
  bit  send_gaps_on;
  bit  stall_gaps_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_string_state();
    wr_slot       = '0;
    chars_seen    = '0;
    firsts_open   = '0;
    seconds_open  = '0;
    pairs_open    = '0;
    running_total = '0;
  endfunction

  // Step the predicted counter by one character word, return the expected result
  function automatic out_word_t count_triples(input in_word_t w);
    int unsigned     span;
    int unsigned     back;
    int unsigned     rd;
    int unsigned     psum;
    logic [63:0]     tsum;
    logic [7:0]      leaving;
    out_word_t       r;
    span = win_len_reg;
    if (span == 0) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    back = span - 1;

    // entering character, first match wins
    if (w.char_in == pat_first) begin
      if (firsts_open != CNT_SAT) firsts_open = firsts_open + 1'b1;
    end else if (w.char_in == pat_second) begin
      psum = pairs_open + firsts_open;
      pairs_open = (psum > PAIR_SAT) ? PAIR_SAT : PAIR_W'(psum);
      if (seconds_open != CNT_SAT) seconds_open = seconds_open + 1'b1;
    end else if (w.char_in == pat_third) begin
      tsum = {1'b0, running_total} + 64'(pairs_open);
      running_total = (tsum > {1'b0, TOTAL_SAT}) ? TOTAL_SAT : tsum[TOTAL_W-1:0];
    end

    char_delay[wr_slot] = w.char_in;

    // leaving character, only once enough of this string has been seen
    if (chars_seen >= back) begin
      rd = (int'(wr_slot) + MAX_WINDOW - back) % MAX_WINDOW;
      leaving = char_delay[rd];
      if (leaving == pat_first) begin
        if (firsts_open != '0) firsts_open = firsts_open - 1'b1;
        pairs_open = (pairs_open > seconds_open) ? pairs_open - seconds_open : '0;
      end else if (leaving == pat_second) begin
        if (seconds_open != '0) seconds_open = seconds_open - 1'b1;
      end
    end

    wr_slot = wr_slot + 1'b1;
    if (chars_seen < MAX_WINDOW) chars_seen = chars_seen + 1'b1;

    r.triple_count = running_total;
    r.final_count  = w.end_of_string;
    if (w.end_of_string) clear_string_state();
    return r;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("%s", msg);
  endtask

  // Send one character word, with a random lead-in gap while send_gaps_on is set
  task automatic send_char(input logic [7:0] ch, input logic eos);
    int       gap;
    in_word_t w;
    gap = send_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    w.char_in       = ch;
    w.end_of_string = eos;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_counts.push_back(count_triples(w));
    words_sent++;
  endtask

  task automatic pause_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle_results();
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the pipeline empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WLEN_W-1:0] value);
    pause_input();
    settle_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_WINDOW_LEN:  win_len_reg = value;
      REG_FIRST_CHAR:  pat_first   = value[7:0];
      REG_SECOND_CHAR: pat_second  = value[7:0];
      REG_THIRD_CHAR:  pat_third   = value[7:0];
      default: ;
    endcase
  endtask

  task automatic send_string(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
    send_char(c0, 1'b0);
    send_char(c1, 1'b0);
    send_char(c2, 1'b1);
  endtask

  // Result checker and output stall generator
  initial begin : result_sink
    int        hold;
    out_word_t want;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          note_failure($sformatf("unexpected result word: count %0d final %0b",
                                 out_data.triple_count, out_data.final_count));
        end else begin
          want = expected_counts.pop_front();
          if (out_data.triple_count !== want.triple_count ||
              out_data.final_count !== want.final_count)
            note_failure($sformatf(
              "mismatch on result %0d: count exp %0d got %0d, final exp %0b got %0b",
              words_checked, want.triple_count, out_data.triple_count,
              want.final_count, out_data.final_count));
          words_checked++;
        end
        hold = stall_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      @(negedge clk);
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  // Watchdog on handshake progress
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Reset pattern D, M, C with window 3
  task automatic test_reset_defaults();
    send_string(FIRST_RST, SECOND_RST, THIRD_RST);
    send_char(FIRST_RST, 1'b0);
    send_char(SECOND_RST, 1'b0);
    send_char(8'h58, 1'b0);
    send_char(THIRD_RST, 1'b1);
  endtask

  // Zero window acts as one, oversize window clamps to the delay depth
  task automatic test_window_extremes();
    write_reg(REG_WINDOW_LEN, '0);
    send_string(FIRST_RST, SECOND_RST, THIRD_RST);
    write_reg(REG_WINDOW_LEN, '1);
    send_string(FIRST_RST, SECOND_RST, THIRD_RST);
  endtask

  // Pattern bytes at the ends and the middle of the byte range
  task automatic test_pattern_extremes();
    write_reg(REG_WINDOW_LEN, WINDOW_LEN_RST);
    write_reg(REG_FIRST_CHAR, 13'h000);
    write_reg(REG_SECOND_CHAR, 13'h0ff);
    write_reg(REG_THIRD_CHAR, 13'h080);
    send_string(8'h00, 8'hff, 8'h80);
  endtask

  // All three pattern bytes equal: every match counts as a first character
  task automatic test_equal_pattern_chars();
    write_reg(REG_FIRST_CHAR, 13'h041);
    write_reg(REG_SECOND_CHAR, 13'h041);
    write_reg(REG_THIRD_CHAR, 13'h041);
    send_string(8'h41, 8'h41, 8'h41);
  endtask

  // Growing the window inside a string removes characters twice; counts floor at zero
  task automatic test_window_grow_mid_string();
    write_reg(REG_FIRST_CHAR, 13'(FIRST_RST));
    write_reg(REG_SECOND_CHAR, 13'(SECOND_RST));
    write_reg(REG_THIRD_CHAR, 13'(THIRD_RST));
    write_reg(REG_WINDOW_LEN, 13'd2);
    send_char(FIRST_RST, 1'b0);
    send_char(FIRST_RST, 1'b0);
    send_char(FIRST_RST, 1'b0);
    write_reg(REG_WINDOW_LEN, 13'd3);
    mid_string_changes++;
    send_char(SECOND_RST, 1'b0);
    send_char(THIRD_RST, 1'b1);
  endtask

  function automatic logic [WLEN_W-1:0] pick_window();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 13'd1;
      2:       return 13'(MAX_WINDOW);
      3:       return 13'($urandom_range(MAX_WINDOW + 1, 8191));
      4:       return 13'($urandom_range(13, 64));
      default: return 13'($urandom_range(2, 12));
    endcase
  endfunction

  // Mostly pattern bytes so triples form, some noise
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return pat_first;
    if (r < 12) return pat_second;
    if (r < 17) return pat_third;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_strings(input int target);
    int          stop_at;
    int          len;
    int          nstr;
    logic [7:0]  pv;
    logic        eos;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      phases++;
      send_gaps_on  = ($urandom_range(0, 3) != 0);
      stall_gaps_on = ($urandom_range(0, 3) != 0);

      // new settings between strings
      if ($urandom_range(0, 3) != 0) write_reg(REG_WINDOW_LEN, pick_window());
      for (int r = REG_FIRST_CHAR; r <= REG_THIRD_CHAR; r++) begin
        if ($urandom_range(0, 3) != 0) begin
          pv = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 11))
            0: pv = pat_first;
            1: pv = pat_second;
            default: ;
          endcase
          write_reg(CFG_IDX_W'(r), 13'(pv));
        end
      end

      nstr = $urandom_range(1, 4);
      for (int s = 0; s < nstr && words_sent < stop_at; s++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        // last string is trimmed so the word count lands on the target
        if (len > stop_at - words_sent) len = stop_at - words_sent;
        for (int n = 0; n < len; n++) begin
          eos = (n == len - 1) || ($urandom_range(0, 59) == 0);
          send_char(pick_char(), eos);
          if (n < len - 1 && $urandom_range(0, 49) == 0) begin
            write_reg(REG_WINDOW_LEN, pick_window());
            mid_string_changes++;
          end else if ($urandom_range(0, 79) == 0) begin
            pause_input();
            settle_results();
          end
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_WINDOW_LEN;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    words_sent = 0;
    words_checked = 0;
    failures = 0;
    phases = 0;
    reg_writes = 0;
    mid_string_changes = 0;
    send_gaps_on  = 1'b1;
    stall_gaps_on = 1'b1;
    win_len_reg = WINDOW_LEN_RST;
    pat_first   = FIRST_RST;
    pat_second  = SECOND_RST;
    pat_third   = THIRD_RST;
    clear_string_state();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_window_extremes();
    test_pattern_extremes();
    test_equal_pattern_chars();
    test_window_grow_mid_string();
    test_random_strings(RANDOM_ITEMS);

    pause_input();
    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_counts.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_counts.size()));

    $display("ran %0d words and checked %0d results over %0d random phases",
             words_sent, words_checked, phases);
    $display("%0d register writes, %0d of them window changes inside a string, %0d failures",
             reg_writes, mid_string_changes, failures);
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/wtsc_pkg.sv
hw/rtl/wtsc_ram.sv
hw/rtl/windowed_triple_subsequence_count.sv
hw/rtl/wtsc_checker.sv
bench/windowed_triple_subsequence_count_test.sv
